// ----- rtl/rbcl_pkg.sv -----
// ----------------------------------------------------------------------------
// rbcl_pkg
// Shared types, constants and calendar helpers for the BCD RTC snapshot
// checker and local time core.
// ----------------------------------------------------------------------------
package rbcl_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_DAYS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_HOURS   = 2'd1;
  localparam logic [1:0] REG_OFFSET_MINUTES = 2'd2;
  localparam logic [1:0] REG_OFFSET_SECONDS = 2'd3;

  // stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_DATA_W = 16;

  // calendar and clock constants
  localparam logic [7:0]  BCD_MAX       = 8'h9F;
  localparam logic [7:0]  BCD_BAD       = 8'hFF;
  localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [7:0]  HOUR_LIMIT    = 8'd24;
  localparam logic [7:0]  MIN_LIMIT     = 8'd60;
  localparam logic [7:0]  MIN_WRAP      = 8'd60;
  localparam logic [7:0]  HOUR_WRAP     = 8'd24;
  localparam logic [7:0]  MONTHS        = 8'd12;
  localparam logic [7:0]  FEBRUARY      = 8'd2;
  localparam logic [7:0]  LEAP_SKIP_A   = 8'd100;
  localparam logic [7:0]  LEAP_SKIP_B   = 8'd200;
  localparam logic [3:0]  DEC_DIGIT_MAX = 4'd9;
  localparam logic [3:0]  LAST_CLAMP    = 4'd11;

  // error flag bit positions
  localparam int FLAG_POWER  = 0;
  localparam int FLAG_12H    = 1;
  localparam int FLAG_YEAR   = 2;
  localparam int FLAG_MONTH  = 3;
  localparam int FLAG_DAY    = 4;
  localparam int FLAG_HOUR   = 5;
  localparam int FLAG_MINUTE = 6;
  localparam int FLAG_SECOND = 7;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEARS,
    ST_SUM,
    ST_LOCAL,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic year_step;
    logic sum;
    logic local_sub;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic year_done;
  } status_t;

  // bcd byte to binary, invalid codes give 255
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, v[7:4]};
    lo = {4'd0, v[3:0]};
    if (v > BCD_MAX || v[3:0] > DEC_DIGIT_MAX) begin
      return BCD_BAD;
    end
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // leap year for years 2000 to 2255
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'd0) && (y != LEAP_SKIP_A) && (y != LEAP_SKIP_B);
  endfunction

  // days in month, index 0 is january
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:                 len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:              len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before the given one, index 0 is january
  function automatic logic [15:0] cum_days(input logic [3:0] idx);
    logic [15:0] days;
    case (idx)
      4'd0:    days = 16'd0;
      4'd1:    days = 16'd31;
      4'd2:    days = 16'd59;
      4'd3:    days = 16'd90;
      4'd4:    days = 16'd120;
      4'd5:    days = 16'd151;
      4'd6:    days = 16'd181;
      4'd7:    days = 16'd212;
      4'd8:    days = 16'd243;
      4'd9:    days = 16'd273;
      4'd10:   days = 16'd304;
      default: days = 16'd334;
    endcase
    return days;
  endfunction

endpackage

// ----- rtl/rbcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbcl_ctrl
// Sequencer for one snapshot: load, year accumulation, month and day sum,
// offset subtraction and result hand-off to the output register.
// ----------------------------------------------------------------------------
module rbcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output rbcl_pkg::cmd_t    cmd,
  input  rbcl_pkg::status_t stat
);

  rbcl_pkg::state_t state;
  rbcl_pkg::state_t state_next;
  logic             out_valid;
  logic             out_valid_next;

  // state register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbcl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      rbcl_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = rbcl_pkg::ST_YEARS;
        end
      end
      rbcl_pkg::ST_YEARS: begin
        if (stat.year_done) begin
          state_next = rbcl_pkg::ST_SUM;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      rbcl_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = rbcl_pkg::ST_LOCAL;
      end
      rbcl_pkg::ST_LOCAL: begin
        cmd.local_sub = 1'b1;
        state_next    = rbcl_pkg::ST_EMIT;
      end
      rbcl_pkg::ST_EMIT: begin
        // wait until the output register is free or being emptied
        if (!out_valid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = rbcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rbcl_pkg::ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ----- rtl/rbcl_datapath.sv -----
// ----------------------------------------------------------------------------
// rbcl_datapath
// Offset registers, converted snapshot fields, day count accumulator,
// error flags, borrow chain and the output register.
// ----------------------------------------------------------------------------
module rbcl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_addr,
  input  logic [rbcl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [rbcl_pkg::IN_DATA_W-1:0]      in_data,
  input  rbcl_pkg::cmd_t                      cmd,
  output rbcl_pkg::status_t                   stat,
  output logic [rbcl_pkg::OUT_DATA_W-1:0]     out_data
);

  // offsets
  logic [15:0] off_days;
  logic [7:0]  off_hours;
  logic [7:0]  off_minutes;
  logic [7:0]  off_seconds;

  // converted snapshot
  logic [7:0] yr;
  logic [7:0] mon;
  logic [7:0] dy;
  logic [7:0] hr;
  logic [7:0] mn;
  logic [7:0] sc;
  logic       pwr;
  logic       m24;

  // accumulation and intermediate results
  logic [7:0]  yidx;
  logic [15:0] acc;
  logic [15:0] count;
  logic [7:0]  flags;
  logic [7:0]  raw_s;
  logic [7:0]  raw_m;
  logic [7:0]  raw_h;
  logic [15:0] raw_d;

  // combinational terms
  logic [3:0]  months_n;
  logic        leap_y;
  logic        mon_ok;
  logic [5:0]  lim;
  logic [15:0] count_sum;
  logic [7:0]  flags_sum;
  logic [15:0] year_days;
  logic [7:0]  ls1;
  logic [7:0]  lm0;
  logic [7:0]  lm1;
  logic [7:0]  lh0;
  logic [7:0]  lh1;
  logic [15:0] ld1;

  // offset register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      off_days    <= '0;
      off_hours   <= '0;
      off_minutes <= '0;
      off_seconds <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rbcl_pkg::REG_OFFSET_DAYS:    off_days    <= cfg_wdata;
        rbcl_pkg::REG_OFFSET_HOURS:   off_hours   <= cfg_wdata[7:0];
        rbcl_pkg::REG_OFFSET_MINUTES: off_minutes <= cfg_wdata[7:0];
        rbcl_pkg::REG_OFFSET_SECONDS: off_seconds <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // days in the current year step
  assign year_days = rbcl_pkg::DAYS_PER_YEAR + {15'd0, rbcl_pkg::is_leap(yidx)};
  assign stat.year_done = (yidx == yr);

  // month index clamp and day limit
  always_comb begin
    if (mon == 8'd0) begin
      months_n = 4'd0;
    end else if (mon > rbcl_pkg::MONTHS) begin
      months_n = rbcl_pkg::LAST_CLAMP;
    end else begin
      months_n = 4'(mon - 8'd1);
    end
  end

  assign leap_y = rbcl_pkg::is_leap(yr);
  assign mon_ok = (mon != 8'd0) && (mon <= rbcl_pkg::MONTHS);
  assign lim    = {1'b0, rbcl_pkg::month_len(months_n)}
                + {5'd0, (mon == rbcl_pkg::FEBRUARY) && leap_y};

  // final day count
  assign count_sum = acc + rbcl_pkg::cum_days(months_n)
                   + {15'd0, (mon > rbcl_pkg::FEBRUARY) && leap_y}
                   + {8'd0, dy};

  // error flags
  always_comb begin
    flags_sum = '0;
    flags_sum[rbcl_pkg::FLAG_POWER]  = pwr;
    flags_sum[rbcl_pkg::FLAG_12H]    = !m24;
    flags_sum[rbcl_pkg::FLAG_YEAR]   = (yr == rbcl_pkg::BCD_BAD);
    flags_sum[rbcl_pkg::FLAG_MONTH]  = !mon_ok;
    flags_sum[rbcl_pkg::FLAG_DAY]    = (mon_ok && (dy > {2'd0, lim}))
                                     || (dy == rbcl_pkg::BCD_BAD);
    flags_sum[rbcl_pkg::FLAG_HOUR]   = (hr > rbcl_pkg::HOUR_LIMIT);
    flags_sum[rbcl_pkg::FLAG_MINUTE] = (mn > rbcl_pkg::MIN_LIMIT);
    flags_sum[rbcl_pkg::FLAG_SECOND] = (sc > rbcl_pkg::MIN_LIMIT);
  end

  // borrow chain seconds to minutes to hours to days
  always_comb begin
    ls1 = raw_s[7] ? raw_s + rbcl_pkg::MIN_WRAP : raw_s;
    lm0 = raw_m - {7'd0, raw_s[7]};
    lm1 = lm0[7] ? lm0 + rbcl_pkg::MIN_WRAP : lm0;
    lh0 = raw_h - {7'd0, lm0[7]};
    lh1 = lh0[7] ? lh0 + rbcl_pkg::HOUR_WRAP : lh0;
    ld1 = raw_d - {15'd0, lh0[7]};
  end

  // snapshot capture and per-step datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yr   <= rbcl_pkg::bcd_to_bin(in_data[7:0]);
      mon  <= rbcl_pkg::bcd_to_bin(in_data[15:8]);
      dy   <= rbcl_pkg::bcd_to_bin(in_data[23:16]);
      hr   <= rbcl_pkg::bcd_to_bin(in_data[31:24]);
      mn   <= rbcl_pkg::bcd_to_bin(in_data[39:32]);
      sc   <= rbcl_pkg::bcd_to_bin(in_data[47:40]);
      pwr  <= in_data[48];
      m24  <= in_data[49];
      yidx <= '0;
      acc  <= '0;
    end
    if (cmd.year_step) begin
      acc  <= acc + year_days;
      yidx <= yidx + 8'd1;
    end
    if (cmd.sum) begin
      count <= count_sum;
      flags <= flags_sum;
    end
    if (cmd.local_sub) begin
      raw_s <= sc - off_seconds;
      raw_m <= mn - off_minutes;
      raw_h <= hr - off_hours;
      raw_d <= count - off_days;
    end
    if (cmd.emit) begin
      out_data <= {ls1, lm1, lh1, ld1, count, flags};
    end
  end

endmodule

// ----- rtl/rtc_bcd_check_and_local_time_core.sv -----
// ----------------------------------------------------------------------------
// rtc_bcd_check_and_local_time_core
// Checks one BCD RTC snapshot, counts days since 2000 and forms local time
// against the stored day, hour, minute and second offsets.
// ----------------------------------------------------------------------------
//  channel   dir  width  content
//  s_axis    in   56     snapshot: year, month, day, hour, minute, second,
//                        power_failed, mode_24h
//  m_axis    out  64     error_flags, day_count, local_days, local_hours,
//                        local_minutes, local_seconds
//  cfg       in   2+16   offset register writes, no read-back
//
//  After the transfer, the year sum adds one year per cycle in a single
//  accumulator up to the converted year (0 to 99, 255 when the year byte is
//  not BCD); the day sum, offset subtraction and hand-off follow in order.
//  One snapshot is in flight at a time; s_tready is high only when idle.
//  A finished result waits in the output register while the next snapshot
//  is taken; a stalled m_tready holds the core before it overwrites it.
//  rst is synchronous and clears the offsets, the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module rtc_bcd_check_and_local_time_core (
  input  logic                            clk,
  input  logic                            rst,
  // year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd,
  // power_failed, mode_24h, zero fill
  input  logic [rbcl_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // error_flags, day_count, local_days, local_hours, local_minutes,
  // local_seconds
  output logic [rbcl_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_addr,
  input  logic [rbcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rbcl_pkg::cmd_t    cmd;
  rbcl_pkg::status_t stat;

  // sequencer
  rbcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic and registers
  rbcl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

// ----- rtl/rbcl_checker.sv -----
// ----------------------------------------------------------------------------
// rbcl_checker
// Port-level checks on the snapshot core handshakes and sequencing.
// ----------------------------------------------------------------------------
module rbcl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rbcl_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result payload changed while stalled");

  // the core is busy right after a snapshot transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("snapshot taken while busy");

  // no result can appear the cycle after a snapshot into an empty output
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  // a blocked output keeps a busy core from going idle
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !s_tready |=> !s_tready)
    else $error("core went idle with its result blocked");

endmodule

bind rtc_bcd_check_and_local_time_core rbcl_checker u_rbcl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/tb_rtc_bcd_check_and_local_time_core.sv -----
// ----------------------------------------------------------------------------
// tb_rtc_bcd_check_and_local_time_core
// Self-checking bench for the BCD RTC snapshot checker. Snapshots go in over
// the slave stream and results come back on the master stream. A scoreboard
// computes error flags, day count and local time for each accepted snapshot
// and compares every returned field in order. Offsets are rewritten between
// bursts while the core is idle, and both stream sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// one snapshot, year in the lowest bits
typedef struct packed {
  logic       mode_24h;
  logic       power_failed;
  logic [7:0] second;
  logic [7:0] minute;
  logic [7:0] hour;
  logic [7:0] day;
  logic [7:0] month;
  logic [7:0] year;
} snapshot_t;

// one result, error flags in the lowest bits
typedef struct packed {
  logic [7:0]  local_seconds;
  logic [7:0]  local_minutes;
  logic [7:0]  local_hours;
  logic [15:0] local_days;
  logic [15:0] day_count;
  logic [7:0]  flags;
} local_time_t;

class local_time_scoreboard;
  local_time_t expected_times[$];
  logic [15:0] off_days;
  logic [7:0]  off_hours;
  logic [7:0]  off_minutes;
  logic [7:0]  off_seconds;
  int          errors;

  function new();
    off_days    = '0;
    off_hours   = '0;
    off_minutes = '0;
    off_seconds = '0;
    errors      = 0;
  endfunction

  function void set_offset(logic [1:0] addr, logic [15:0] value);
    case (addr)
      rbcl_pkg::REG_OFFSET_DAYS:    off_days    = value;
      rbcl_pkg::REG_OFFSET_HOURS:   off_hours   = value[7:0];
      rbcl_pkg::REG_OFFSET_MINUTES: off_minutes = value[7:0];
      default:                      off_seconds = value[7:0];
    endcase
  endfunction

  // bcd byte to binary, non-decimal codes map to 255
  function int bcd_decode(logic [7:0] b);
    if (b > rbcl_pkg::BCD_MAX || b[3:0] > 4'd9) return 255;
    return 10 * b[7:4] + b[3:0];
  endfunction

  function bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // month index 0 is january
  function int month_days(int idx);
    case (idx)
      1:            return 28;
      3, 5, 8, 10:  return 30;
      default:      return 31;
    endcase
  endfunction

  function local_time_t predict_local_time(snapshot_t sn);
    int          y, mo, d, h, mi, s, lim, months;
    logic [31:0] count;
    logic [7:0]  ls, lm, lh;
    logic [15:0] ld;
    local_time_t r;
    y  = bcd_decode(sn.year);
    mo = bcd_decode(sn.month);
    d  = bcd_decode(sn.day);
    h  = bcd_decode(sn.hour);
    mi = bcd_decode(sn.minute);
    s  = bcd_decode(sn.second);

    // error flags, day length only checked for a real month
    r.flags = '0;
    r.flags[rbcl_pkg::FLAG_POWER] = sn.power_failed;
    r.flags[rbcl_pkg::FLAG_12H]   = !sn.mode_24h;
    r.flags[rbcl_pkg::FLAG_YEAR]  = (y == 255);
    if (mo == 0 || mo > 12) begin
      r.flags[rbcl_pkg::FLAG_MONTH] = 1'b1;
    end else begin
      lim = month_days(mo - 1) + ((mo == 2 && leap_year(y)) ? 1 : 0);
      if (d > lim) r.flags[rbcl_pkg::FLAG_DAY] = 1'b1;
    end
    if (d == 255) r.flags[rbcl_pkg::FLAG_DAY] = 1'b1;
    r.flags[rbcl_pkg::FLAG_HOUR]   = (h > 24);
    r.flags[rbcl_pkg::FLAG_MINUTE] = (mi > 60);
    r.flags[rbcl_pkg::FLAG_SECOND] = (s > 60);

    // days since 2000, month sum clamped for bad months
    count = 0;
    for (int i = 0; i < y; i++) count += 365 + (leap_year(i) ? 1 : 0);
    months = (mo == 0) ? 0 : ((mo > 12) ? 11 : mo - 1);
    for (int i = 0; i < months; i++) count += month_days(i);
    if (mo > 2 && leap_year(y)) count += 1;
    count += d;
    r.day_count = count[15:0];

    // local time with borrows, everything wraps at field width
    ls = 8'(s)  - off_seconds;
    lm = 8'(mi) - off_minutes;
    lh = 8'(h)  - off_hours;
    ld = count[15:0] - off_days;
    if (ls[7]) begin
      ls = ls + 8'd60;
      lm = lm - 8'd1;
    end
    if (lm[7]) begin
      lm = lm + 8'd60;
      lh = lh - 8'd1;
    end
    if (lh[7]) begin
      lh = lh + 8'd24;
      ld = ld - 16'd1;
    end
    r.local_seconds = ls;
    r.local_minutes = lm;
    r.local_hours   = lh;
    r.local_days    = ld;
    return r;
  endfunction

  function void note_snapshot(snapshot_t sn);
    expected_times.push_back(predict_local_time(sn));
  endfunction

  function void compare_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp_v,
               act_v);
      errors++;
    end
  endfunction

  function void check_result(logic [rbcl_pkg::OUT_DATA_W-1:0] data);
    local_time_t got, want;
    got = data;
    if (expected_times.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual %h", $time, data);
      errors++;
      return;
    end
    want = expected_times.pop_front();
    compare_field("error_flags",   want.flags,         got.flags);
    compare_field("day_count",     want.day_count,     got.day_count);
    compare_field("local_days",    want.local_days,    got.local_days);
    compare_field("local_hours",   want.local_hours,   got.local_hours);
    compare_field("local_minutes", want.local_minutes, got.local_minutes);
    compare_field("local_seconds", want.local_seconds, got.local_seconds);
  endfunction

  function bit idle();
    return expected_times.size() == 0;
  endfunction
endclass

module tb_rtc_bcd_check_and_local_time_core;

  logic                            clk;
  logic                            rst;
  logic [rbcl_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [rbcl_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic                            cfg_wr_en;
  logic [1:0]                      cfg_addr;
  logic [rbcl_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              steady;

  local_time_scoreboard board;

  rtc_bcd_check_and_local_time_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls at random, with a chance of 11 in a hundred
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 11);
  end

  // check every result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  function automatic logic [7:0] to_bcd(int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic snapshot_t make_snap(logic [7:0] y, logic [7:0] mo, logic [7:0] d,
                                          logic [7:0] h, logic [7:0] mi, logic [7:0] s,
                                          logic pf, logic m24);
    snapshot_t sn;
    sn.year         = y;
    sn.month        = mo;
    sn.day          = d;
    sn.hour         = h;
    sn.minute       = mi;
    sn.second       = s;
    sn.power_failed = pf;
    sn.mode_24h     = m24;
    return sn;
  endfunction

  // mostly in range, some out of range decimal, some raw bytes
  function automatic logic [7:0] pick_bcd(int lo, int hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return to_bcd($urandom_range(hi, lo));
    if (roll < 90) return to_bcd($urandom_range(99));
    return 8'($urandom_range(255));
  endfunction

  function automatic snapshot_t random_snapshot();
    return make_snap(pick_bcd(0, 99), pick_bcd(1, 12),
                     pick_bcd(1, ($urandom_range(3) == 0) ? 31 : 28),
                     pick_bcd(0, 23), pick_bcd(0, 59), pick_bcd(0, 59),
                     $urandom_range(9) == 0, $urandom_range(9) != 0);
  endfunction

  // one snapshot transfer, valid stays high on return
  task automatic send_snapshot(input snapshot_t sn);
    while (!steady && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(rbcl_pkg::IN_DATA_W - $bits(snapshot_t)){1'b0}}, sn};
    do @(posedge clk); while (!s_tready);
    board.note_snapshot(sn);
    @(negedge clk);
  endtask

  // close a burst and wait for every result
  task automatic end_burst();
    s_tvalid <= 1'b0;
    while (!board.idle()) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_offset(input logic [1:0] addr, input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    board.set_offset(addr, value);
  endtask

  task automatic apply_offsets(input logic [15:0] d, input logic [7:0] h,
                               input logic [7:0] mi, input logic [7:0] s);
    write_offset(rbcl_pkg::REG_OFFSET_DAYS, d);
    write_offset(rbcl_pkg::REG_OFFSET_HOURS, {{8{h[7]}}, h});
    write_offset(rbcl_pkg::REG_OFFSET_MINUTES, {{8{mi[7]}}, mi});
    write_offset(rbcl_pkg::REG_OFFSET_SECONDS, {{8{s[7]}}, s});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    for (int i = 0; i < n_items; i++) send_snapshot(random_snapshot());
    end_burst();
  endtask

  initial begin
    board     = new();
    clk       = 1'b0;
    rst       = 1'b1;
    s_tdata   = '0;
    s_tvalid  = 1'b0;
    m_tready  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = rbcl_pkg::REG_OFFSET_DAYS;
    cfg_wdata = '0;
    steady    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed snapshots with the reset offsets
    send_snapshot(make_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, 1'b0, 1'b1));
    send_snapshot(make_snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_snapshot(make_snap(8'hA0, 8'h0A, 8'h9F, 8'h1A, 8'hA5, 8'h3C, 1'b0, 1'b1));
    // leap day in 2000, missing leap day in 2001, day 30 in a leap february
    send_snapshot(make_snap(8'h00, 8'h02, 8'h29, 8'h12, 8'h30, 8'h30, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h01, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h04, 8'h02, 8'h30, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    // april 31, month 13, month 20, december
    send_snapshot(make_snap(8'h10, 8'h04, 8'h31, 8'h01, 8'h02, 8'h03, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h24, 8'h13, 8'h15, 8'h05, 8'h06, 8'h07, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h96, 8'h20, 8'h40, 8'h05, 8'h06, 8'h07, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h23, 8'h12, 8'h01, 8'h05, 8'h06, 8'h07, 1'b0, 1'b1));
    // hour, minute and second right at and just past their limits
    send_snapshot(make_snap(8'h05, 8'h06, 8'h07, 8'h24, 8'h60, 8'h60, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h05, 8'h06, 8'h07, 8'h25, 8'h61, 8'h61, 1'b0, 1'b1));
    // status bits alone
    send_snapshot(make_snap(8'h12, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 1'b1, 1'b1));
    send_snapshot(make_snap(8'h12, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 1'b0, 1'b0));
    // day 0 after february in a leap year, and in month 0
    send_snapshot(make_snap(8'h08, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h08, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    // a bad second byte pushes a borrow through every field
    send_snapshot(make_snap(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hAA, 1'b0, 1'b1));
    send_snapshot(make_snap(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0));
    end_burst();

    // offsets at the positive extremes, then the negative ones
    apply_offsets(16'h7FFF, 8'h7F, 8'h7F, 8'h7F);
    send_snapshot(make_snap(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    run_random(150);
    apply_offsets(16'h8000, 8'h80, 8'h80, 8'h80);
    send_snapshot(make_snap(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, 1'b0, 1'b1));
    run_random(150);

    // small offsets, no stalls on either side
    steady = 1'b1;
    apply_offsets(16'd1, 8'd2, 8'd30, 8'd45);
    run_random(150);
    steady = 1'b0;

    apply_offsets(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(150);
    repeat (3) begin
      apply_offsets(16'($urandom_range(65535)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random(150);
    end

    // stray results show up in the scoreboard during this wait
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("rtc_bcd_check_and_local_time_core regression: pass");
    end else begin
      $display("rtc_bcd_check_and_local_time_core regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("rtc_bcd_check_and_local_time_core regression: fail");
    $finish;
  end

endmodule

// ----- rtc_bcd_check_and_local_time_core.f -----
rtl/rbcl_pkg.sv
rtl/rbcl_ctrl.sv
rtl/rbcl_datapath.sv
rtl/rtc_bcd_check_and_local_time_core.sv
rtl/rbcl_checker.sv
sim/tb_rtc_bcd_check_and_local_time_core.sv
